/* design/drs_pkg.sv */
package drs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned CYL_W = 8;
  localparam int unsigned SEEK_W = 14;
  localparam int unsigned REV_W = 6;
  localparam logic [SEEK_W-1:0] SEEK_MAX = 14'h3fff;
  localparam logic [REV_W-1:0] REV_MAX = 6'h3f;
  localparam logic [CYL_W-1:0] TOP_RESET = 8'hff;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SSTF  = 2'd1,
    POL_SCAN  = 2'd2,
    POL_CLOOK = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    CFG_POLICY     = 2'd0,
    CFG_START_HEAD = 2'd1,
    CFG_TOP_CYL    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BEGIN,
    ST_START,
    ST_SCAN,
    ST_FLUSH,
    ST_DECIDE,
    ST_SERVE
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic scan_start;
    logic scan_rd;
    logic phase_sw;
    logic serve;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic out_busy;
    logic final_req;
  } status_t;

endpackage

/* design/drs_ctrl.sv */
module drs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_batch_end,
  output logic             in_stall,
  input  drs_pkg::status_t st,
  output drs_pkg::cmd_t    cmd
);

  drs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= drs_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      drs_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && in_batch_end) state_nxt = drs_pkg::ST_BEGIN;
      end
      drs_pkg::ST_BEGIN: begin
        cmd.init = 1'b1;
        state_nxt = drs_pkg::ST_START;
      end
      drs_pkg::ST_START: begin
        cmd.scan_start = 1'b1;
        state_nxt = drs_pkg::ST_SCAN;
      end
      drs_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.scan_last) state_nxt = drs_pkg::ST_FLUSH;
      end
      drs_pkg::ST_FLUSH: begin
        state_nxt = drs_pkg::ST_DECIDE;
      end
      drs_pkg::ST_DECIDE: begin
        if (st.found) begin
          state_nxt = drs_pkg::ST_SERVE;
        end else begin
          // nothing left above the head: turn around and search again
          cmd.phase_sw = 1'b1;
          state_nxt = drs_pkg::ST_START;
        end
      end
      drs_pkg::ST_SERVE: begin
        if (!st.out_busy) begin
          cmd.serve = 1'b1;
          state_nxt = st.final_req ? drs_pkg::ST_LOAD : drs_pkg::ST_START;
        end
      end
      default: state_nxt = drs_pkg::ST_LOAD;
    endcase
  end

endmodule

/* design/drs_dp.sv */
module drs_dp #(
  parameter int unsigned QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [drs_pkg::CYL_W-1:0]     cfg_wdata,
  input  logic [drs_pkg::CYL_W-1:0]     in_cylinder,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [drs_pkg::CYL_W-1:0]     out_served_cylinder,
  output logic [drs_pkg::SEEK_W-1:0]    out_seek_total,
  output logic [drs_pkg::REV_W-1:0]     out_direction_changes,
  output logic                          out_run_last,
  input  drs_pkg::cmd_t                 cmd,
  output drs_pkg::status_t              st
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CYL_W = drs_pkg::CYL_W;
  localparam int unsigned SEEK_W = drs_pkg::SEEK_W;
  localparam int unsigned REV_W = drs_pkg::REV_W;
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  logic [CYL_W-1:0] mem [QUEUE_DEPTH];

  drs_pkg::policy_t   policy_r;
  logic [CYL_W-1:0]   start_head_r, top_r;
  logic [CW-1:0]      count_r, rem_r, scan_cnt_r;
  logic [QUEUE_DEPTH-1:0] pending_r;
  logic [CYL_W-1:0]   head_r;
  logic [SEEK_W-1:0]  seek_r;
  logic [REV_W-1:0]   rev_r;
  logic               phase_r;
  logic [CYL_W-1:0]   rdata_r;
  logic [AW-1:0]      rd_idx_r;
  logic               rd_vld_r;
  logic               found_r;
  logic [CYL_W-1:0]   best_key_r, best_cyl_r;
  logic [AW-1:0]      best_idx_r;
  logic               out_vld_r, out_last_r;
  logic [CYL_W-1:0]   out_cyl_r;
  logic [SEEK_W-1:0]  out_seek_r;
  logic [REV_W-1:0]   out_rev_r;

  logic               elig;
  logic [CYL_W-1:0]   key;
  logic [CYL_W-1:0]   tgt, mv_dist;
  logic               up;
  logic [SEEK_W:0]    seek_sum;
  logic [SEEK_W-1:0]  seek_nxt;
  logic [REV_W-1:0]   rev_nxt;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load && count_r < FULL) mem[count_r[AW-1:0]] <= in_cylinder;
    rdata_r  <= mem[scan_cnt_r[AW-1:0]];
    rd_idx_r <= scan_cnt_r[AW-1:0];
  end

  // search key of the word just read
  always_comb begin
    elig = pending_r[rd_idx_r];
    key  = '0;
    unique case (policy_r)
      drs_pkg::POL_FCFS: key = '0;
      drs_pkg::POL_SSTF: key = (rdata_r >= head_r) ? rdata_r - head_r : head_r - rdata_r;
      drs_pkg::POL_SCAN: begin
        if (!phase_r) begin
          elig = elig && (rdata_r >= start_head_r);
          key  = rdata_r;
        end else begin
          key = ~rdata_r;
        end
      end
      drs_pkg::POL_CLOOK: begin
        if (!phase_r) elig = elig && (rdata_r >= start_head_r);
        key = rdata_r;
      end
      default: key = '0;
    endcase
  end

  // one move of the head, shared by serve and the scan travel to the top
  always_comb begin
    tgt = cmd.phase_sw ? top_r : best_cyl_r;
    up = tgt >= head_r;
    mv_dist = up ? tgt - head_r : head_r - tgt;
    seek_sum = {1'b0, seek_r} + (SEEK_W+1)'(mv_dist);
    seek_nxt = (seek_sum > {1'b0, drs_pkg::SEEK_MAX}) ? drs_pkg::SEEK_MAX
                                                      : seek_sum[SEEK_W-1:0];
    rev_nxt = rev_r;
    if ((up == rev_r[0]) && (rev_r != drs_pkg::REV_MAX)) rev_nxt = rev_r + REV_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= drs_pkg::POL_FCFS;
      start_head_r <= '0;
      top_r        <= drs_pkg::TOP_RESET;
      count_r      <= '0;
      rem_r        <= '0;
      scan_cnt_r   <= '0;
      pending_r    <= '0;
      head_r       <= '0;
      seek_r       <= '0;
      rev_r        <= '0;
      phase_r      <= 1'b0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          drs_pkg::CFG_POLICY:     policy_r <= drs_pkg::policy_t'(cfg_wdata[1:0]);
          drs_pkg::CFG_START_HEAD: start_head_r <= cfg_wdata;
          drs_pkg::CFG_TOP_CYL:    top_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load && count_r < FULL) begin
        pending_r[count_r[AW-1:0]] <= 1'b1;
        count_r <= count_r + CW'(1);
      end
      if (cmd.init) begin
        head_r  <= start_head_r;
        seek_r  <= '0;
        rev_r   <= '0;
        phase_r <= 1'b0;
        rem_r   <= count_r;
      end
      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
        found_r    <= 1'b0;
      end else if (cmd.scan_rd) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
      rd_vld_r <= cmd.scan_rd;
      if (rd_vld_r && elig && (!found_r || key < best_key_r)) begin
        found_r    <= 1'b1;
        best_key_r <= key;
        best_cyl_r <= rdata_r;
        best_idx_r <= rd_idx_r;
      end
      if (cmd.phase_sw) begin
        phase_r <= 1'b1;
        if (policy_r == drs_pkg::POL_SCAN) begin
          head_r <= top_r;
          seek_r <= seek_nxt;
        end
      end
      if (out_vld_r && !out_stall && !cmd.serve) out_vld_r <= 1'b0;
      if (cmd.serve) begin
        head_r     <= best_cyl_r;
        seek_r     <= seek_nxt;
        rev_r      <= rev_nxt;
        out_vld_r  <= 1'b1;
        out_cyl_r  <= best_cyl_r;
        out_seek_r <= seek_nxt;
        out_rev_r  <= rev_nxt;
        out_last_r <= (rem_r == CW'(1));
        rem_r <= rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          count_r   <= '0;
          pending_r <= '0;
        end else begin
          pending_r[best_idx_r] <= 1'b0;
        end
      end
    end
  end

  assign st.scan_last = (scan_cnt_r + CW'(1)) == count_r;
  assign st.found     = found_r;
  assign st.out_busy  = out_vld_r && out_stall;
  assign st.final_req = rem_r == CW'(1);

  assign out_valid             = out_vld_r;
  assign out_served_cylinder   = out_cyl_r;
  assign out_seek_total        = out_seek_r;
  assign out_direction_changes = out_rev_r;
  assign out_run_last          = out_last_r;

endmodule

/* design/disk_request_scheduler.sv */
// Disk request scheduler.
// Input channel (in_valid/in_stall, in_cylinder, in_batch_end) loads one
// request word per cycle into a request store. The word with in_batch_end
// set closes the batch; words beyond QUEUE_DEPTH are dropped but still end it.
// The block then stalls the input and emits every stored request on the
// output channel (out_valid/out_stall) in the order of the policy register:
// FCFS, SSTF, SCAN or C-LOOK, each word carrying the running seek total and
// reversal count; out_run_last marks the final word of the batch.
// Each result comes from a full pass over the stored batch through one
// memory read port, and the SCAN/C-LOOK turnaround adds a further pass.
// The output register holds a word while out_stall is high, and the input
// reopens as soon as the last word is registered. The user must write
// configuration (cfg_we, cfg_index, cfg_wdata) only between batches; the
// block does not enforce this. Synchronous reset (rst_n low) empties the
// store, selects FCFS, start head 0 and top cylinder 255.
module disk_request_scheduler #(
  parameter int unsigned QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [drs_pkg::CYL_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [drs_pkg::CYL_W-1:0]     in_cylinder,
  input  logic                          in_batch_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [drs_pkg::CYL_W-1:0]     out_served_cylinder,
  output logic [drs_pkg::SEEK_W-1:0]    out_seek_total,
  output logic [drs_pkg::REV_W-1:0]     out_direction_changes,
  output logic                          out_run_last
);

  drs_pkg::cmd_t    cmd;
  drs_pkg::status_t st;

  drs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_batch_end (in_batch_end),
    .in_stall     (in_stall),
    .st           (st),
    .cmd          (cmd)
  );

  drs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_cylinder           (in_cylinder),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_served_cylinder   (out_served_cylinder),
    .out_seek_total        (out_seek_total),
    .out_direction_changes (out_direction_changes),
    .out_run_last          (out_run_last),
    .cmd                   (cmd),
    .st                    (st)
  );

`ifndef SYNTH
  a_serve_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.serve |-> !st.out_busy)
    else $error("serve while output word is held");

  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.serve && st.final_req |=> !in_stall)
    else $error("input not reopened after final word");

  a_mid_batch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> in_stall)
    else $error("input reopened in the middle of a batch");
`endif

endmodule
